@@ rtl/slm_pkg.sv @@
// Shared constants for the stereo level meter with packet gap check.
// Depends on nothing; used by the channel unit and the top level.
package slm_pkg;

    localparam int TIME_BITS   = 48;
    localparam int ENERGY_BITS = 64;
    localparam int FPP_BITS    = 13;

    localparam logic [FPP_BITS-1:0] FPP_RESET = 13'd480;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_RESYNC = 1'b1;

endpackage

@@ rtl/slm_channel.sv @@
// Per-channel energy and peak update for one sample.
// Depends on slm_pkg for the energy width.
module slm_channel #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    input  logic        [slm_pkg::ENERGY_BITS-1:0] i_energy,
    input  logic        [SAMPLE_BITS-1:0]          i_peak,
    output logic        [slm_pkg::ENERGY_BITS-1:0] o_energy,
    output logic        [SAMPLE_BITS-1:0]          o_peak
);

    localparam int EW = slm_pkg::ENERGY_BITS;
    localparam int SQ = 2 * SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ-1:0]          square;
    logic [EW:0]            sum;

    // The most negative code maps to 2^(SAMPLE_BITS-1), which still fits unsigned.
    assign mag    = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
    assign square = SQ'(mag) * SQ'(mag);
    assign sum    = {1'b0, i_energy} + {{(EW + 1 - SQ){1'b0}}, square};

    assign o_energy = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];
    assign o_peak   = (mag > i_peak) ? mag : i_peak;

endmodule

@@ rtl/stereo_level_meter_gap_check.sv @@
// Stereo level meter with packet timestamp gap check, top level.
// An accepted item is held in the input register, then moves into the statistics registers.
// Throughput: one item per cycle while the result channel is not stalled.
// Reset (synchronous, active low) clears all statistics and handshake state and
// sets frames_per_packet to 480. Depends on slm_pkg and slm_channel.
module stereo_level_meter_gap_check #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_wr_en,
    input  logic [slm_pkg::FPP_BITS-1:0]          i_cfg_wr_data,
    // Input channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_kind,
    input  logic                                  i_packet_start,
    input  logic [slm_pkg::TIME_BITS-1:0]         i_packet_time,
    input  logic signed [SAMPLE_BITS-1:0]         i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]         i_right_sample,
    // Result channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [COUNT_BITS-1:0]                 o_packet_total,
    output logic [COUNT_BITS-1:0]                 o_frame_total,
    output logic [COUNT_BITS-1:0]                 o_gap_total,
    output logic [COUNT_BITS-1:0]                 o_missing_total,
    output logic [slm_pkg::TIME_BITS-1:0]         o_largest_gap,
    output logic [COUNT_BITS-1:0]                 o_differing_total,
    output logic [slm_pkg::ENERGY_BITS-1:0]       o_left_energy,
    output logic [slm_pkg::ENERGY_BITS-1:0]       o_right_energy,
    output logic [SAMPLE_BITS-1:0]                o_left_max_mag,
    output logic [SAMPLE_BITS-1:0]                o_right_max_mag
);

    localparam int TW    = slm_pkg::TIME_BITS;
    localparam int EW    = slm_pkg::ENERGY_BITS;
    // Width wide enough to add a time difference to a count without losing the carry.
    localparam int SUM_W = ((COUNT_BITS > TW) ? COUNT_BITS : TW) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_W-1:0]      COUNT_MAX_W = {{(SUM_W - COUNT_BITS){1'b0}}, COUNT_MAX};

    // Input register. The item waits here while its update is computed.
    logic                          r_in_valid;
    logic                          r_kind;
    logic                          r_start;
    logic [TW-1:0]                 r_time;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;

    logic [slm_pkg::FPP_BITS-1:0]  r_fpp;

    // Running statistics. Since each result is a snapshot taken right after its item,
    // these registers double as the result register and drive the outputs directly.
    logic                          r_has_prev;
    logic [TW-1:0]                 r_expected;
    logic [COUNT_BITS-1:0]         r_packets;
    logic [COUNT_BITS-1:0]         r_frames;
    logic [COUNT_BITS-1:0]         r_gaps;
    logic [COUNT_BITS-1:0]         r_missing;
    logic [TW-1:0]                 r_max_gap;
    logic [COUNT_BITS-1:0]         r_differ;
    logic [EW-1:0]                 r_left_energy;
    logic [EW-1:0]                 r_right_energy;
    logic [SAMPLE_BITS-1:0]        r_left_max_mag;
    logic [SAMPLE_BITS-1:0]        r_right_max_mag;
    logic                          r_out_valid;

    logic                          n_has_prev;
    logic [TW-1:0]                 n_expected;
    logic [COUNT_BITS-1:0]         n_packets;
    logic [COUNT_BITS-1:0]         n_frames;
    logic [COUNT_BITS-1:0]         n_gaps;
    logic [COUNT_BITS-1:0]         n_missing;
    logic [TW-1:0]                 n_max_gap;
    logic [COUNT_BITS-1:0]         n_differ;
    logic [EW-1:0]                 n_left_energy;
    logic [EW-1:0]                 n_right_energy;
    logic [SAMPLE_BITS-1:0]        n_left_max_mag;
    logic [SAMPLE_BITS-1:0]        n_right_max_mag;

    logic                          in_accept;
    logic                          advance;
    logic                          is_gap;
    logic                          is_forward;
    logic [TW-1:0]                 miss;
    logic [SUM_W-1:0]              missing_sum;
    logic [EW-1:0]                 left_energy_upd;
    logic [EW-1:0]                 right_energy_upd;
    logic [SAMPLE_BITS-1:0]        left_max_mag_upd;
    logic [SAMPLE_BITS-1:0]        right_max_mag_upd;

    // The held item moves into the statistics when the result slot is free or being
    // taken. A new item can enter while a finished result still waits downstream.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    slm_channel #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_left (
        .i_sample (r_left),
        .i_energy (r_left_energy),
        .i_peak   (r_left_max_mag),
        .o_energy (left_energy_upd),
        .o_peak   (left_max_mag_upd)
    );

    slm_channel #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_right (
        .i_sample (r_right),
        .i_energy (r_right_energy),
        .i_peak   (r_right_max_mag),
        .o_energy (right_energy_upd),
        .o_peak   (right_max_mag_upd)
    );

    // Gap check: a packet start after a known packet whose timestamp is off the
    // prediction. Only a later timestamp adds missing frames.
    assign is_gap      = r_start && r_has_prev && (r_time != r_expected);
    assign is_forward  = r_time > r_expected;
    assign miss        = r_time - r_expected;
    assign missing_sum = SUM_W'(r_missing) + SUM_W'(miss);

    always_comb begin
        n_has_prev      = r_has_prev;
        n_expected      = r_expected;
        n_packets       = r_packets;
        n_frames        = r_frames;
        n_gaps          = r_gaps;
        n_missing       = r_missing;
        n_max_gap       = r_max_gap;
        n_differ        = r_differ;
        n_left_energy   = r_left_energy;
        n_right_energy  = r_right_energy;
        n_left_max_mag  = r_left_max_mag;
        n_right_max_mag = r_right_max_mag;
        if (r_kind == slm_pkg::KIND_RESYNC) begin
            // A resync only forgets the previous packet; no statistic moves.
            n_has_prev = 1'b0;
        end else begin
            if (r_start) begin
                if (is_gap) begin
                    if (r_gaps != COUNT_MAX) begin
                        n_gaps = r_gaps + 1'b1;
                    end
                    if (is_forward) begin
                        n_missing = (missing_sum > COUNT_MAX_W) ? COUNT_MAX
                                                                : missing_sum[COUNT_BITS-1:0];
                        if (miss > r_max_gap) begin
                            n_max_gap = miss;
                        end
                    end
                end
                if (r_packets != COUNT_MAX) begin
                    n_packets = r_packets + 1'b1;
                end
                n_has_prev = 1'b1;
                n_expected = r_time + TW'(r_fpp);
            end
            if (r_frames != COUNT_MAX) begin
                n_frames = r_frames + 1'b1;
            end
            if ((r_left != r_right) && (r_differ != COUNT_MAX)) begin
                n_differ = r_differ + 1'b1;
            end
            n_left_energy   = left_energy_upd;
            n_right_energy  = right_energy_upd;
            n_left_max_mag  = left_max_mag_upd;
            n_right_max_mag = right_max_mag_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= i_kind;
            r_start <= i_packet_start;
            r_time  <= i_packet_time;
            r_left  <= i_left_sample;
            r_right <= i_right_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpp <= slm_pkg::FPP_RESET;
        end else if (i_cfg_wr_en) begin
            r_fpp <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_prev      <= 1'b0;
            r_expected      <= '0;
            r_packets       <= '0;
            r_frames        <= '0;
            r_gaps          <= '0;
            r_missing       <= '0;
            r_max_gap       <= '0;
            r_differ        <= '0;
            r_left_energy   <= '0;
            r_right_energy  <= '0;
            r_left_max_mag  <= '0;
            r_right_max_mag <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (advance) begin
                r_has_prev      <= n_has_prev;
                r_expected      <= n_expected;
                r_packets       <= n_packets;
                r_frames        <= n_frames;
                r_gaps          <= n_gaps;
                r_missing       <= n_missing;
                r_max_gap       <= n_max_gap;
                r_differ        <= n_differ;
                r_left_energy   <= n_left_energy;
                r_right_energy  <= n_right_energy;
                r_left_max_mag  <= n_left_max_mag;
                r_right_max_mag <= n_right_max_mag;
                r_out_valid     <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_packet_total    = r_packets;
    assign o_frame_total     = r_frames;
    assign o_gap_total       = r_gaps;
    assign o_missing_total   = r_missing;
    assign o_largest_gap     = r_max_gap;
    assign o_differing_total = r_differ;
    assign o_left_energy     = r_left_energy;
    assign o_right_energy    = r_right_energy;
    assign o_left_max_mag    = r_left_max_mag;
    assign o_right_max_mag   = r_right_max_mag;

    // A resync item must leave the frame count untouched.
    a_resync_keeps_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_kind == slm_pkg::KIND_RESYNC)) |=> $stable(r_frames))
        else $error("resync item changed the frame count");

    // Input side stalls only while an item is held and cannot move on.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked item");

    // Gaps are counted only on packet starts, so they never outnumber packets.
    a_gaps_within_packets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gaps <= r_packets)
        else $error("gap count exceeds packet count");

    // The frame count never goes backward outside reset.
    a_frames_monotonic: assert property (@(posedge i_clk)
        $past(i_rst_n) |-> (r_frames >= $past(r_frames)))
        else $error("frame count decreased");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stereo_level_meter_gap_check: a directed table of items,
// then random packet streams, scored against written-out snapshots or a bench predictor.
// Depends on slm_pkg and the RTL of stereo_level_meter_gap_check.
module tb_top;

    // The watchdog limit covers the long receiver hold plus the worst random stall runs.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    // An accepted item passes the input and statistics registers; the settle wait is margin.
    localparam int SETTLE_CYCLES  = 4;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_ITEMS  = 82;
    localparam int MAX_REPORTS    = 10;
    localparam int OPENING_ROWS   = 19;

    // One input item as the sender presents it.
    typedef struct packed {
        logic                          kind;
        logic                          start;
        logic [slm_pkg::TIME_BITS-1:0] stamp;
        logic [15:0]                   left;
        logic [15:0]                   right;
    } meter_item_t;

    // One snapshot of the statistics, in the order of the result ports.
    typedef struct packed {
        logic [47:0] packets;
        logic [47:0] frames;
        logic [47:0] gaps;
        logic [47:0] missing;
        logic [47:0] widest;
        logic [47:0] differing;
        logic [63:0] left_energy;
        logic [63:0] right_energy;
        logic [15:0] left_max_mag;
        logic [15:0] right_max_mag;
    } meter_stats_t;

    // A row of the opening table. When typed is set, want is the snapshot written out
    // by hand and is checked instead of the predicted one.
    typedef struct packed {
        logic         typed;
        meter_item_t  item;
        meter_stats_t want;
    } plan_row_t;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_wr_en    = 1'b0;
    logic [slm_pkg::FPP_BITS-1:0]  i_cfg_wr_data  = slm_pkg::FPP_RESET;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic                          i_kind         = slm_pkg::KIND_FRAME;
    logic                          i_packet_start = 1'b0;
    logic [slm_pkg::TIME_BITS-1:0] i_packet_time  = '0;
    logic [15:0]                   i_left_sample  = '0;
    logic [15:0]                   i_right_sample = '0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic [47:0]                   o_packet_total;
    logic [47:0]                   o_frame_total;
    logic [47:0]                   o_gap_total;
    logic [47:0]                   o_missing_total;
    logic [47:0]                   o_largest_gap;
    logic [47:0]                   o_differing_total;
    logic [63:0]                   o_left_energy;
    logic [63:0]                   o_right_energy;
    logic [15:0]                   o_left_max_mag;
    logic [15:0]                   o_right_max_mag;

    // Predictor state: the frames-per-packet setting, the has-previous mark, the time
    // the next packet should carry, and the running statistics themselves.
    logic [slm_pkg::FPP_BITS-1:0]  fpp_setting   = slm_pkg::FPP_RESET;
    logic                          stream_locked = 1'b0;
    logic [slm_pkg::TIME_BITS-1:0] next_stamp    = '0;
    meter_stats_t                  tally         = '0;

    // Snapshots still owed by the block, oldest first.
    meter_stats_t stats_due[$];

    int   faults          = 0;
    int   items_sent      = 0;
    int   results_checked = 0;
    int   settings_used   = 0;
    int   send_idle_pct   = 8;
    int   stall_pct       = 50;
    int   hold_left       = 0;
    logic hold_pending    = 1'b0;

    // The opening table: the first three rows have their snapshots written out, since
    // they follow directly from reset. The rest walk through gap detection with the
    // reset setting of 480 frames per packet: in-order packets, a late and an early
    // packet, a resync, timestamp wrap at the top of the 48-bit range, saturation of
    // the missing-frame sum and the sample extremes.
    plan_row_t opening_rows [OPENING_ROWS] = '{
        '{1'b1, '{slm_pkg::KIND_RESYNC, 1'b0, 48'd0, 16'h0000, 16'h0000}, '0},
        '{1'b1, '{slm_pkg::KIND_FRAME, 1'b0, 48'd0, 16'h8000, 16'h7FFF},
              '{48'd0, 48'd1, 48'd0, 48'd0, 48'd0, 48'd1,
                64'd1073741824, 64'd1073676289, 16'd32768, 16'd32767}},
        '{1'b1, '{slm_pkg::KIND_FRAME, 1'b1, 48'd1000, 16'h0000, 16'h0000},
              '{48'd1, 48'd2, 48'd0, 48'd0, 48'd0, 48'd1,
                64'd1073741824, 64'd1073676289, 16'd32768, 16'd32767}},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b1, 48'd1480, 16'h7FFF, 16'h7FFF}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b1, 48'd1480, 16'h0100, 16'hFF00}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b1, 48'd5000, 16'h1234, 16'h1234}, '0},
        '{1'b0, '{slm_pkg::KIND_RESYNC, 1'b1, 48'd7, 16'hFFFF, 16'h0005}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b1, 48'd9999, 16'h0001, 16'h0002}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b1, 48'hFFFF_FFFF_FFFF, 16'h0000, 16'h0000}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b1, 48'd479, 16'h0000, 16'h0000}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b1, 48'hFFFF_FFFF_FFFF, 16'h0000, 16'h0000}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b1, 48'd0, 16'h0000, 16'h0000}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b0, 48'd0, 16'hFFFF, 16'h0001}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b0, 48'hFFFF_FFFF_FFFF, 16'h0001, 16'hFFFF}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b0, 48'd0, 16'h8000, 16'h8000}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b0, 48'd0, 16'h7FFF, 16'h7FFF}, '0},
        '{1'b0, '{slm_pkg::KIND_RESYNC, 1'b0, 48'hFFFF_FFFF_FFFF, 16'h8000, 16'h7FFF}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b1, 48'd0, 16'h0000, 16'h0000}, '0},
        '{1'b0, '{slm_pkg::KIND_FRAME, 1'b1, 48'd480, 16'h0000, 16'h0000}, '0}
    };

    // Frames-per-packet settings for the random segments; the last one is drawn at random.
    logic [slm_pkg::FPP_BITS-1:0] fpp_plan [SEGMENTS] =
        '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd480, 13'd0};

    stereo_level_meter_gap_check DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_packet_start    (i_packet_start),
        .i_packet_time     (i_packet_time),
        .i_left_sample     (i_left_sample),
        .i_right_sample    (i_right_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_packet_total    (o_packet_total),
        .o_frame_total     (o_frame_total),
        .o_gap_total       (o_gap_total),
        .o_missing_total   (o_missing_total),
        .o_largest_gap     (o_largest_gap),
        .o_differing_total (o_differing_total),
        .o_left_energy     (o_left_energy),
        .o_right_energy    (o_right_energy),
        .o_left_max_mag    (o_left_max_mag),
        .o_right_max_mag   (o_right_max_mag)
    );

    always #10 i_clk = ~i_clk;

    // Saturating adds for the 48-bit counters and the 64-bit energy sums.
    function automatic logic [47:0] add_count(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[48] ? '1 : sum[47:0];
    endfunction

    function automatic logic [63:0] add_energy(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[64] ? '1 : sum[63:0];
    endfunction

    // Magnitude of a Q1.15 sample; the most negative value maps to 32768.
    function automatic logic [15:0] sample_magnitude(input logic [15:0] raw);
        return raw[15] ? (~raw + 16'd1) : raw;
    endfunction

    // Applies one accepted item to the predicted statistics and returns the snapshot
    // that the block should report for it.
    function automatic meter_stats_t advance_meter(input meter_item_t it);
        logic [15:0] lmag;
        logic [15:0] rmag;
        logic [47:0] shortfall;
        if (it.kind == slm_pkg::KIND_RESYNC) begin
            stream_locked = 1'b0;
        end else begin
            if (it.start) begin
                // Only a packet that follows another one is checked against the
                // predicted time. A late packet also adds the frames it skipped.
                if (stream_locked && it.stamp != next_stamp) begin
                    tally.gaps = add_count(tally.gaps, 48'd1);
                    if (it.stamp > next_stamp) begin
                        shortfall = it.stamp - next_stamp;
                        tally.missing = add_count(tally.missing, shortfall);
                        if (shortfall > tally.widest)
                            tally.widest = shortfall;
                    end
                end
                tally.packets = add_count(tally.packets, 48'd1);
                stream_locked = 1'b1;
                // The next packet time wraps at 48 bits.
                next_stamp = it.stamp + 48'(fpp_setting);
            end
            tally.frames = add_count(tally.frames, 48'd1);
            if (it.left != it.right)
                tally.differing = add_count(tally.differing, 48'd1);
            lmag = sample_magnitude(it.left);
            rmag = sample_magnitude(it.right);
            tally.left_energy  = add_energy(tally.left_energy, 64'(lmag) * 64'(lmag));
            tally.right_energy = add_energy(tally.right_energy, 64'(rmag) * 64'(rmag));
            if (lmag > tally.left_max_mag)
                tally.left_max_mag = lmag;
            if (rmag > tally.right_max_mag)
                tally.right_max_mag = rmag;
        end
        return tally;
    endfunction

    function automatic logic [15:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 16'h8000;
        if (roll == 1)
            return 16'h7FFF;
        if (roll == 2)
            return 16'h0000;
        if (roll == 3)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Random items are mostly well-formed streams: packet starts usually carry exactly
    // the predicted time, with some late, early, wild and near-wrap timestamps, and
    // the occasional resync in between.
    function automatic meter_item_t pick_item();
        meter_item_t it;
        int          roll;
        it.kind  = ($urandom_range(0, 99) < 6) ? slm_pkg::KIND_RESYNC : slm_pkg::KIND_FRAME;
        it.start = ($urandom_range(0, 99) < 35);
        roll = $urandom_range(0, 19);
        if (roll < 14)
            it.stamp = next_stamp;
        else if (roll == 14)
            it.stamp = next_stamp + 48'($urandom_range(1, 5000));
        else if (roll == 15)
            it.stamp = next_stamp - 48'($urandom_range(1, 5000));
        else if (roll < 18)
            it.stamp = {16'($urandom), 32'($urandom)};
        else if (roll == 18)
            it.stamp = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 8191));
        else
            it.stamp = 48'($urandom_range(0, 8191));
        it.left  = pick_sample();
        it.right = ($urandom_range(0, 99) < 30) ? it.left : pick_sample();
        return it;
    endfunction

    // Offers one item, with a random idle stretch ahead of it, and waits until the
    // block takes it. Called at a rising edge; returns at the edge of acceptance.
    task automatic offer_item(input meter_item_t it, input logic typed,
                              input meter_stats_t want);
        meter_stats_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= it.kind;
        i_packet_start <= it.start;
        i_packet_time  <= it.stamp;
        i_left_sample  <= it.left;
        i_right_sample <= it.right;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        predicted = advance_meter(it);
        stats_due.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Stops offering and waits until every owed snapshot has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The register is only written with the block idle.
    task automatic write_fpp(input logic [slm_pkg::FPP_BITS-1:0] value);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        fpp_setting = value;
        settings_used++;
    endtask

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            faults++;
            if (faults <= MAX_REPORTS)
                $display("%0t ns: result %0d, %s expected %0d, got %0d",
                         $time, results_checked, field, want, got);
        end
    endfunction

    // Receiver: random stalls at the current rate, and one long hold when the stimulus
    // asks for it, counted here so the sender keeps offering items meanwhile.
    initial begin
        logic hold_started;
        hold_started = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending && !hold_started) begin
                hold_left    = HOLD_CYCLES;
                hold_started = 1'b1;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Scoreboard: every accepted snapshot is matched against the oldest one owed.
    always @(posedge i_clk) begin
        meter_stats_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (stats_due.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("%0t ns: result arrived with no item waiting for it", $time);
            end else begin
                want = stats_due.pop_front();
                compare_field("packet_total", want.packets, o_packet_total);
                compare_field("frame_total", want.frames, o_frame_total);
                compare_field("gap_total", want.gaps, o_gap_total);
                compare_field("missing_total", want.missing, o_missing_total);
                compare_field("largest_gap", want.widest, o_largest_gap);
                compare_field("differing_total", want.differing, o_differing_total);
                compare_field("left_energy", want.left_energy, o_left_energy);
                compare_field("right_energy", want.right_energy, o_right_energy);
                compare_field("left_max_mag", want.left_max_mag, o_left_max_mag);
                compare_field("right_max_mag", want.right_max_mag, o_right_max_mag);
                results_checked++;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves an owed item for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall && stats_due.size() != 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus: reset, the opening table, then six random segments, each under its own
    // frames-per-packet setting. The first two segments idle the sender lightly and
    // the receiver heavily, the next two the other way round, the last two not at all.
    initial begin
        int seg;
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < OPENING_ROWS; row++)
            offer_item(opening_rows[row].item, opening_rows[row].typed, opening_rows[row].want);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < 2) begin
                send_idle_pct = 8;
                stall_pct     = 50;
            end else if (seg < 4) begin
                send_idle_pct = 50;
                stall_pct     = 8;
            end else begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            if (seg == SEGMENTS - 1)
                write_fpp(13'($urandom_range(2, 4095)));
            else
                write_fpp(fpp_plan[seg]);
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                // Once the receiver holds off long enough for the block to fill up and
                // stall its input; once the sender stops until everything is back.
                if (seg == 1 && n == 20)
                    hold_pending <= 1'b1;
                if (seg == 3 && n == 40)
                    wait_for_results();
                offer_item(pick_item(), 1'b0, '0);
            end
        end

        wait_for_results();
        $display("Run covered %0d items (%0d from the opening table), %0d results checked.",
                 items_sent, OPENING_ROWS, results_checked);
        $display("It used %0d frames-per-packet settings; %0d gaps and %0d missing frames.",
                 settings_used, tally.gaps, tally.missing);
        if (faults == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
